@@ rtl/drt_pkg.sv @@
// Shared types and constants for the damage rectangle tracker.
`timescale 1ns / 1ps
package drt_pkg;
  localparam int unsigned MaxEntries = 32;
  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned Gap = 2;
  localparam logic [13:0] ScreenMax = 14'd8192;

  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpFill  = 2'd1,
    OpDrain = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
  } box_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e  op;
    logic empty;
    box_t box;
  } cmd_t;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;
endpackage

@@ rtl/damage_rectangle_tracker_core.sv @@
// Top level of the damage rectangle tracker.
`timescale 1ns / 1ps
// Keeps up to 32 clipped damage rectangles. A front end clips each beat and
// queues it (two deep); a back-end sequencer walks the table through one
// shared merge unit, visiting each entry with a read, an operand and a decide
// step. An add first scans the table for a merge, then makes an absorb pass,
// moving the last entry into each freed slot. A drain emits one beat per
// entry and holds while the output is stalled. Screen sizes written on the
// config port saturate to 1..8192.
module damage_rectangle_tracker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] rect_left_i,
  input  logic signed [15:0] rect_top_i,
  input  logic [15:0]        rect_width_i,
  input  logic [15:0]        rect_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               has_rect_o,
  output logic [12:0]        out_left_o,
  output logic [12:0]        out_top_o,
  output logic [13:0]        out_width_o,
  output logic [13:0]        out_height_o,
  output logic               last_of_run_o,
  output logic [5:0]         entries_held_o
);
  logic [13:0] scr_w_q, scr_h_q, clamp;
  logic cmd_valid, cmd_take;
  drt_pkg::cmd_t cmd;

  assign clamp = (cfg_data_i == '0) ? 14'd1 :
                 (cfg_data_i > drt_pkg::ScreenMax) ? drt_pkg::ScreenMax : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 14'd1024;
      scr_h_q <= 14'd768;
    end else if (cfg_we_i) begin
      if (cfg_index_i == drt_pkg::RegWidth) scr_w_q <= clamp;
      else scr_h_q <= clamp;
    end
  end

  drt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .rect_left_i,
    .rect_top_i, .rect_width_i, .rect_height_i, .scr_w_i(scr_w_q),
    .scr_h_i(scr_h_q), .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take),
    .cmd_o(cmd)
  );

  drt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd), .scr_w_i(scr_w_q), .scr_h_i(scr_h_q), .out_valid_o,
    .out_stall_i, .has_rect_o, .out_left_o, .out_top_o, .out_width_o,
    .out_height_o, .last_of_run_o, .entries_held_o
  );
endmodule

@@ rtl/drt_front.sv @@
// Front end: clips incoming rectangles and queues classified commands.
`timescale 1ns / 1ps
module drt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic signed [15:0] rect_left_i,
  input  logic signed [15:0] rect_top_i,
  input  logic [15:0]       rect_width_i,
  input  logic [15:0]       rect_height_i,
  input  logic [13:0]       scr_w_i,
  input  logic [13:0]       scr_h_i,
  output logic              cmd_valid_o,
  input  logic              cmd_take_i,
  output drt_pkg::cmd_t     cmd_o
);
  logic signed [17:0] left, top, right, bottom, cl, ct, cr, cb;
  drt_pkg::cmd_t cmd;
  drt_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  logic push;

  always_comb begin
    left   = 18'(rect_left_i);
    top    = 18'(rect_top_i);
    right  = left + $signed({2'b00, rect_width_i});
    bottom = top + $signed({2'b00, rect_height_i});
    cl = left < 0 ? 18'sd0 : left;
    ct = top < 0 ? 18'sd0 : top;
    cr = right > $signed({4'b0, scr_w_i}) ? $signed({4'b0, scr_w_i}) : right;
    cb = bottom > $signed({4'b0, scr_h_i}) ? $signed({4'b0, scr_h_i}) : bottom;
    cmd.op = drt_pkg::op_e'(operation_i);
    cmd.empty = (cr <= cl) || (cb <= ct);
    cmd.box.x = cl[12:0];
    cmd.box.y = ct[12:0];
    cmd.box.w = 14'(cr - cl);
    cmd.box.h = 14'(cb - ct);
  end

  assign in_stall_o  = cnt_q == 2'd2;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_q[rd_q];
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_take_i && cmd_valid_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (cmd_take_i && cmd_valid_o) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= cmd;
  end
endmodule

@@ rtl/drt_merge.sv @@
// Merge test: nearness and the area rule for two boxes, registered.
`timescale 1ns / 1ps
module drt_merge (
  input  logic          clk_i,
  input  drt_pkg::box_t a_i,
  input  drt_pkg::box_t b_i,
  output logic          ok_o,
  output drt_pkg::box_t u_o
);
  logic [14:0] ar, ab, br, bb, ux, uy, urr, ubb;
  logic near;
  logic [27:0] aa_q, ba_q, ua_q;
  logic near_q;
  drt_pkg::box_t u, u_q;
  logic [28:0] s;
  logic [28:0] d;
  logic [30:0] d3;

  always_comb begin
    ar = {2'b0, a_i.x} + {1'b0, a_i.w};
    ab = {2'b0, a_i.y} + {1'b0, a_i.h};
    br = {2'b0, b_i.x} + {1'b0, b_i.w};
    bb = {2'b0, b_i.y} + {1'b0, b_i.h};
    near = ({2'b0, a_i.x} <= br + 15'(drt_pkg::Gap)) &&
           ({2'b0, b_i.x} <= ar + 15'(drt_pkg::Gap)) &&
           ({2'b0, a_i.y} <= bb + 15'(drt_pkg::Gap)) &&
           ({2'b0, b_i.y} <= ab + 15'(drt_pkg::Gap));
    ux  = a_i.x < b_i.x ? {2'b0, a_i.x} : {2'b0, b_i.x};
    uy  = a_i.y < b_i.y ? {2'b0, a_i.y} : {2'b0, b_i.y};
    urr = ar > br ? ar : br;
    ubb = ab > bb ? ab : bb;
    u.x = ux[12:0];
    u.y = uy[12:0];
    u.w = 14'(urr - ux);
    u.h = 14'(ubb - uy);
  end

  always_ff @(posedge clk_i) begin
    aa_q   <= a_i.w * a_i.h;
    ba_q   <= b_i.w * b_i.h;
    ua_q   <= u.w * u.h;
    near_q <= near;
    u_q    <= u;
  end

  // union <= s + floor(s/3) holds exactly when 3 * (union - s) <= s
  always_comb begin
    s    = {1'b0, aa_q} + {1'b0, ba_q};
    d    = {1'b0, ua_q} - s;
    d3   = {1'b0, d, 1'b0} + {2'b0, d};
    ok_o = near_q && (({1'b0, ua_q} <= s) || (d3 <= {2'b0, s}));
    u_o  = u_q;
  end
endmodule

@@ rtl/drt_back.sv @@
// Back end: table sequencer for merge, absorb, append, fill and drain.
`timescale 1ns / 1ps
module drt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_take_o,
  input  drt_pkg::cmd_t         cmd_i,
  input  logic [13:0]           scr_w_i,
  input  logic [13:0]           scr_h_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  has_rect_o,
  output logic [12:0]           out_left_o,
  output logic [12:0]           out_top_o,
  output logic [13:0]           out_width_o,
  output logic [13:0]           out_height_o,
  output logic                  last_of_run_o,
  output logic [5:0]            entries_held_o
);
  localparam int unsigned IW = drt_pkg::IdxW;
  localparam int unsigned CW = drt_pkg::CntW;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StScanR = 11'b00000000010,
    StScanM = 11'b00000000100,
    StScanT = 11'b00000001000,
    StAbsR  = 11'b00000010000,
    StAbsM  = 11'b00000100000,
    StAbsT  = 11'b00001000000,
    StMove  = 11'b00010000000,
    StMoveW = 11'b00100000000,
    StDrain = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e state_q;
  drt_pkg::box_t mem [drt_pkg::MaxEntries];
  drt_pkg::box_t rd_q, nb_q, acc_q, mb_u;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  drt_pkg::box_t wd;
  logic [CW-1:0] cnt_q, i_q, j_q;
  logic          mb_ok;
  drt_pkg::box_t ma, mbx;
  logic          ov_q, hr_q, last_q;
  drt_pkg::box_t ob_q;
  logic [5:0]    eh_q;
  logic          out_free;
  logic          dr_pend_q;
  drt_pkg::box_t full_box;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  drt_merge u_merge (.clk_i(clk_i), .a_i(ma), .b_i(mbx), .ok_o(mb_ok), .u_o(mb_u));

  assign full_box   = '{x: '0, y: '0, w: scr_w_i, h: scr_h_i};
  assign out_free   = !ov_q || !out_stall_i;
  assign cmd_take_o = state_q == StIdle && cmd_valid_i && out_free;

  // read address follows the current scan pointer; the merge result comes from
  // the registered read data through the merge unit's own register
  always_comb begin
    unique case (state_q)
      StIdle:  rd_addr = '0;
      StMove:  rd_addr = cnt_q[IW-1:0];
      StDrain: rd_addr = i_q[IW-1:0];
      StAbsR, StAbsM, StAbsT: rd_addr = j_q[IW-1:0];
      default: rd_addr = i_q[IW-1:0];
    endcase
    ma  = (state_q == StScanM) ? rd_q : acc_q;
    mbx = (state_q == StScanM) ? nb_q : rd_q;
    we = 1'b0; wa = '0; wd = rd_q;
    case (state_q)
      StIdle: begin
        if (cmd_take_o && cmd_i.op == drt_pkg::OpFill) begin
          we = 1'b1; wd = full_box;
        end else if (cmd_take_o && cmd_i.op == drt_pkg::OpAdd && !cmd_i.empty &&
                     cnt_q == '0) begin
          we = 1'b1; wd = cmd_i.box;
        end
      end
      StScanT: begin
        if (mb_ok) begin
          we = 1'b1; wa = i_q[IW-1:0]; wd = mb_u;
        end else if (i_q + CW'(1) >= cnt_q) begin
          if (cnt_q >= CW'(drt_pkg::MaxEntries)) begin
            we = 1'b1; wd = full_box;
          end else begin
            we = 1'b1; wa = cnt_q[IW-1:0]; wd = nb_q;
          end
        end
      end
      StAbsT: begin
        if (mb_ok) begin
          we = 1'b1; wa = i_q[IW-1:0]; wd = mb_u;
        end
      end
      StMoveW: begin
        we = 1'b1; wa = j_q[IW-1:0]; wd = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0; i_q <= '0; j_q <= '0;
      ov_q <= 1'b0; dr_pend_q <= 1'b0;
      hr_q <= 1'b0; last_q <= 1'b0; ob_q <= '0; eh_q <= '0;
      nb_q <= '0; acc_q <= '0;
    end else begin
      if (ov_q && !out_stall_i && state_q != StOut) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_take_o) begin
            if (cmd_i.op == drt_pkg::OpDrain && cnt_q != '0) begin
              dr_pend_q <= 1'b1;
              i_q <= '0;
              state_q <= StDrain;
            end else if (cmd_i.op == drt_pkg::OpFill) begin
              cnt_q <= CW'(1);
              state_q <= StOut;
            end else if (cmd_i.op == drt_pkg::OpAdd && !cmd_i.empty && cnt_q != '0) begin
              nb_q <= cmd_i.box;
              i_q <= '0;
              state_q <= StScanR;
            end else if (cmd_i.op == drt_pkg::OpAdd && !cmd_i.empty) begin
              // empty table: the box goes straight into slot 0
              cnt_q <= CW'(1);
              state_q <= StOut;
            end else begin
              state_q <= StOut;
            end
          end
        end
        StScanR: state_q <= StScanM;
        StScanM: state_q <= StScanT;
        StScanT: begin
          if (mb_ok) begin
            acc_q <= mb_u;
            j_q <= '0;
            state_q <= StAbsR;
          end else if (i_q + CW'(1) < cnt_q) begin
            i_q <= i_q + CW'(1);
            state_q <= StScanR;
          end else if (cnt_q >= CW'(drt_pkg::MaxEntries)) begin
            cnt_q <= CW'(1);
            state_q <= StOut;
          end else begin
            cnt_q <= cnt_q + CW'(1);
            state_q <= StOut;
          end
        end
        StAbsR: begin
          if (j_q >= cnt_q) state_q <= StOut;
          else if (j_q == i_q) j_q <= j_q + CW'(1);
          else state_q <= StAbsM;
        end
        StAbsM: state_q <= StAbsT;
        StAbsT: begin
          if (mb_ok) begin
            acc_q <= mb_u;
            cnt_q <= cnt_q - CW'(1);
            if (j_q != cnt_q - CW'(1)) begin
              if (i_q == cnt_q - CW'(1)) i_q <= j_q;
              state_q <= StMove;
            end else begin
              state_q <= StAbsR;
            end
          end else begin
            j_q <= j_q + CW'(1);
            state_q <= StAbsR;
          end
        end
        StMove: state_q <= StMoveW;
        // last entry lands in the freed slot, which is examined again
        StMoveW: state_q <= StAbsR;
        StDrain: state_q <= StOut;
        StOut: begin
          if (out_free) begin
            ov_q <= 1'b1;
            if (dr_pend_q) begin
              hr_q <= 1'b1; ob_q <= rd_q; eh_q <= '0;
              last_q <= i_q + CW'(1) == cnt_q;
              if (i_q + CW'(1) == cnt_q) begin
                cnt_q <= '0;
                dr_pend_q <= 1'b0;
                state_q <= StIdle;
              end else begin
                i_q <= i_q + CW'(1);
                state_q <= StDrain;
              end
            end else begin
              hr_q <= 1'b0; ob_q <= '0; last_q <= 1'b1;
              eh_q <= 6'(cnt_q);
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign has_rect_o    = hr_q;
  assign out_left_o    = ob_q.x;
  assign out_top_o     = ob_q.y;
  assign out_width_o   = ob_q.w;
  assign out_height_o  = ob_q.h;
  assign last_of_run_o = last_q;
  assign entries_held_o = eh_q;
endmodule

@@ dv/damage_rectangle_tracker_core_test.sv @@
// Self-checking testbench for the damage rectangle tracker core.
`timescale 1ns / 1ps
module damage_rectangle_tracker_core_test;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] wid;
    logic [15:0] hgt;
  } damage_beat_t;

  typedef struct packed {
    logic        has_rect;
    logic [12:0] left;
    logic [12:0] top;
    logic [13:0] wid;
    logic [13:0] hgt;
    logic        last;
    logic [5:0]  held;
  } report_t;

  typedef struct {
    longint x, y, w, h;
  } rect_t;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [13:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] op_d;
  logic signed [15:0] left_d, top_d;
  logic [15:0] wid_d, hgt_d;
  logic out_valid, out_stall;
  logic has_rect;
  logic [12:0] out_left, out_top;
  logic [13:0] out_wid, out_hgt;
  logic last_of_run;
  logic [5:0] held;

  damage_rectangle_tracker_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(op_d), .rect_left_i(left_d), .rect_top_i(top_d),
    .rect_width_i(wid_d), .rect_height_i(hgt_d),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .has_rect_o(has_rect), .out_left_o(out_left), .out_top_o(out_top),
    .out_width_o(out_wid), .out_height_o(out_hgt),
    .last_of_run_o(last_of_run), .entries_held_o(held)
  );

  damage_beat_t pending_beats[$];
  report_t      awaited_reports[$];
  rect_t        damage_list[drt_pkg::MaxEntries];
  int           damage_count;
  longint       scr_w, scr_h;
  int           errors;
  longint       cycles;
  bit           in_calm, out_calm;
  int           hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint size_sat(logic [13:0] v);
    if (v == 0) return 1;
    if (v > drt_pkg::ScreenMax) return drt_pkg::ScreenMax;
    return v;
  endfunction

  function automatic bit rects_close(rect_t a, rect_t b);
    return a.x <= b.x + b.w + drt_pkg::Gap && b.x <= a.x + a.w + drt_pkg::Gap &&
           a.y <= b.y + b.h + drt_pkg::Gap && b.y <= a.y + a.h + drt_pkg::Gap;
  endfunction

  // merges b into a when close and the union is not too wasteful
  function automatic bit absorb(ref rect_t a, input rect_t b);
    rect_t u;
    longint s;
    if (!rects_close(a, b)) return 0;
    u.x = (a.x < b.x) ? a.x : b.x;
    u.y = (a.y < b.y) ? a.y : b.y;
    u.w = ((a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w) - u.x;
    u.h = ((a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h) - u.y;
    s = a.w * a.h + b.w * b.h;
    if (u.w * u.h > s + s / 3) return 0;
    a = u;
    return 1;
  endfunction

  function automatic void cover_screen();
    damage_count = 1;
    damage_list[0] = '{0, 0, scr_w, scr_h};
  endfunction

  function automatic void add_damage(damage_beat_t b);
    longint l, t, r, btm;
    rect_t nb;
    int i, j;
    l = longint'($signed(b.left));
    t = longint'($signed(b.top));
    r = l + b.wid;
    btm = t + b.hgt;
    if (l < 0) l = 0;
    if (t < 0) t = 0;
    if (r > scr_w) r = scr_w;
    if (btm > scr_h) btm = scr_h;
    if (r <= l || btm <= t) return;
    nb = '{l, t, r - l, btm - t};
    for (i = 0; i < damage_count; i++) begin
      if (!absorb(damage_list[i], nb)) continue;
      j = 0;
      while (j < damage_count) begin
        if (j == i || !absorb(damage_list[i], damage_list[j])) begin
          j++;
          continue;
        end
        damage_count--;
        if (j != damage_count) begin
          damage_list[j] = damage_list[damage_count];
          if (i == damage_count) i = j;
        end
      end
      return;
    end
    if (damage_count >= drt_pkg::MaxEntries) begin
      cover_screen();
      return;
    end
    damage_list[damage_count] = nb;
    damage_count++;
  endfunction

  function automatic void predict_reports(damage_beat_t b);
    report_t rp;
    if (b.op == drt_pkg::OpDrain && damage_count != 0) begin
      for (int k = 0; k < damage_count; k++) begin
        rp.has_rect = 1'b1;
        rp.left = damage_list[k].x[12:0];
        rp.top  = damage_list[k].y[12:0];
        rp.wid  = damage_list[k].w[13:0];
        rp.hgt  = damage_list[k].h[13:0];
        rp.last = (k + 1 == damage_count);
        rp.held = '0;
        awaited_reports.push_back(rp);
      end
      damage_count = 0;
      return;
    end
    if (b.op == drt_pkg::OpAdd) add_damage(b);
    else if (b.op == drt_pkg::OpFill) cover_screen();
    rp = '0;
    rp.last = 1'b1;
    rp.held = damage_count[5:0];
    awaited_reports.push_back(rp);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_reports('{op_d, left_d, top_d, wid_d, hgt_d});
        void'(pending_beats.pop_front());
      end
      if ((!in_valid || !in_stall) && pending_beats.size() > 0 &&
          (!in_valid || !in_stall) ) begin
        // next beat, skipping the one just taken
        if (pending_beats.size() > 0 && (in_calm || $urandom_range(99) >= 35)) begin
          in_valid <= 1'b1;
          op_d   <= pending_beats[0].op;
          left_d <= pending_beats[0].left;
          top_d  <= pending_beats[0].top;
          wid_d  <= pending_beats[0].wid;
          hgt_d  <= pending_beats[0].hgt;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_off  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected beat has_rect=%0d held=%0d", $time, has_rect, held);
          errors++;
        end else begin
          report_t e;
          e = awaited_reports.pop_front();
          if (e.has_rect != has_rect) begin
            $display("%0t: has_rect exp %0d got %0d", $time, e.has_rect, has_rect); errors++;
          end
          if (e.left != out_left) begin
            $display("%0t: out_left exp %0d got %0d", $time, e.left, out_left); errors++;
          end
          if (e.top != out_top) begin
            $display("%0t: out_top exp %0d got %0d", $time, e.top, out_top); errors++;
          end
          if (e.wid != out_wid) begin
            $display("%0t: out_width exp %0d got %0d", $time, e.wid, out_wid); errors++;
          end
          if (e.hgt != out_hgt) begin
            $display("%0t: out_height exp %0d got %0d", $time, e.hgt, out_hgt); errors++;
          end
          if (e.last != last_of_run) begin
            $display("%0t: last_of_run exp %0d got %0d", $time, e.last, last_of_run); errors++;
          end
          if (e.held != held) begin
            $display("%0t: entries_held exp %0d got %0d", $time, e.held, held); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off  <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !out_calm && ($urandom_range(99) < 35);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic damage_beat_t mk(logic [1:0] op, int l, int t, int w, int h);
    return '{op, l[15:0], t[15:0], w[15:0], h[15:0]};
  endfunction

  function automatic damage_beat_t rand_beat(int span);
    int p;
    damage_beat_t b;
    p = $urandom_range(99);
    if (p < 4) return mk(drt_pkg::OpFill, $urandom, $urandom, $urandom, $urandom);
    if (p < 10) return mk(drt_pkg::OpDrain, $urandom, $urandom, $urandom, $urandom);
    if (p < 12) return mk(drt_pkg::OpNone, $urandom, $urandom, $urandom, $urandom);
    if (p < 20) return mk(drt_pkg::OpAdd, $urandom, $urandom, $urandom, $urandom);
    b = mk(drt_pkg::OpAdd, int'($urandom_range(span + 40)) - 20,
           int'($urandom_range(span + 40)) - 20,
           $urandom_range(60), $urandom_range(60));
    return b;
  endfunction

  task automatic settle();
    while (pending_beats.size() > 0 || in_valid || awaited_reports.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [13:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == drt_pkg::RegWidth) scr_w = size_sat(v); else scr_h = size_sat(v);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; op_d = '0; left_d = '0; top_d = '0; wid_d = '0; hgt_d = '0;
    out_stall = 1'b0;
    errors = 0; cycles = 0; damage_count = 0; hold_off = 0;
    scr_w = 1024; scr_h = 768;
    in_calm = 0; out_calm = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clipping, empties, merges, operations
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    pending_beats.push_back(mk(drt_pkg::OpAdd, -32768, -32768, 65535, 65535));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 10, 10, 0, 5));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 10, 10, 5, 0));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 32767, 32767, 65535, 65535));
    pending_beats.push_back(mk(drt_pkg::OpAdd, -100, -100, 50, 50));
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 100, 100, 20, 20));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 122, 100, 20, 20));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 300, 300, 10, 10));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 500, 500, 10, 10));
    pending_beats.push_back(mk(drt_pkg::OpAdd, 310, 300, 190, 210));
    pending_beats.push_back(mk(drt_pkg::OpNone, -1, -1, 65535, 65535));
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    pending_beats.push_back(mk(drt_pkg::OpFill, 0, 0, 0, 0));
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    for (int k = 0; k < 33; k++)
      pending_beats.push_back(mk(drt_pkg::OpAdd, (k % 8) * 120, (k / 8) * 120, 10, 10));
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    settle();

    write_reg(drt_pkg::RegWidth, 14'd0);
    write_reg(drt_pkg::RegHeight, 14'h3fff);
    pending_beats.push_back(mk(drt_pkg::OpAdd, -5, 8000, 100, 500));
    pending_beats.push_back(mk(drt_pkg::OpFill, 0, 0, 0, 0));
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    settle();

    write_reg(drt_pkg::RegWidth, 14'd8192);
    write_reg(drt_pkg::RegHeight, 14'd1);
    pending_beats.push_back(mk(drt_pkg::OpAdd, 8190, 0, 10, 10));
    pending_beats.push_back(mk(drt_pkg::OpFill, 0, 0, 0, 0));
    pending_beats.push_back(mk(drt_pkg::OpDrain, 0, 0, 0, 0));
    settle();

    // random phases at several screen sizes
    for (int ph = 0; ph < 3; ph++) begin
      int span;
      write_reg(drt_pkg::RegWidth, ph == 0 ? 14'd1024 : 14'($urandom_range(1, 16383)));
      write_reg(drt_pkg::RegHeight, ph == 0 ? 14'd768 : 14'($urandom_range(1, 16383)));
      span = int'(scr_w < scr_h ? scr_w : scr_h);
      if (span > 600) span = 600;
      if (ph == 1) begin
        in_calm = 1; out_calm = 1;
      end else begin
        in_calm = 0; out_calm = 0;
      end
      for (int k = 0; k < 40; k++) pending_beats.push_back(rand_beat(span));
      if (ph == 2) hold_off = 2000;
      settle();
    end
    in_calm = 0; out_calm = 0;

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
